@@ hdl/nrl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrl_pkg: shared types and constants for the nearest region lookup
// Region entry layout, sequencer states, datapath control and status groups,
// command and register codes.
// ----------------------------------------------------------------------------
package nrl_pkg;

	localparam int COORD_W = 16;
	localparam int DIM_W   = 15;
	localparam int DIFF_W  = 18;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int CNT_W   = 4;
	localparam int OUT_W   = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [31:0] BEST_INIT = 32'hffff_ffff;

	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_REGION_COUNT = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [DIM_W-1:0]   w;
		logic        [DIM_W-1:0]   h;
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_SQX,
		ST_SQY,
		ST_ACC,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic eval;
		logic sqx;
		logic sqy;
		logic acc;
	} dp_ctrl_t;

	typedef struct packed {
		logic hit;
		logic closer;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/nrl_dist_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrl_dist_unit: containment test and squared centre distance
// Tests one entry against the point, then squares the two offsets on one
// shared multiplier and keeps the running minimum distance.
// ----------------------------------------------------------------------------
module nrl_dist_unit
	import nrl_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  dp_ctrl_t                  ctrl,
	input  region_t                   entry,
	input  wire logic signed [COORD_W-1:0] px,
	input  wire logic signed [COORD_W-1:0] py,
	output dp_stat_t                  stat
);

	logic signed [COORD_W:0]  x_end;
	logic signed [COORD_W:0]  y_end;
	logic signed [COORD_W:0]  cx;
	logic signed [COORD_W:0]  cy;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [DIFF_W-1:0] mult_a;
	logic signed [SQ_W-1:0]   prod;
	logic        [SQ_W-1:0]   sqx_q;
	logic        [SQ_W-1:0]   sqy_q;
	logic        [SQ_W:0]     dist_sum;
	logic        [31:0]       best_q;

	assign x_end = {entry.x[COORD_W-1], entry.x} + $signed({2'b00, entry.w});
	assign y_end = {entry.y[COORD_W-1], entry.y} + $signed({2'b00, entry.h});
	assign cx    = {entry.x[COORD_W-1], entry.x} + $signed({3'b000, entry.w[DIM_W-1:1]});
	assign cy    = {entry.y[COORD_W-1], entry.y} + $signed({3'b000, entry.h[DIM_W-1:1]});
	assign dx    = {{2{px[COORD_W-1]}}, px} - {cx[COORD_W], cx};
	assign dy    = {{2{py[COORD_W-1]}}, py} - {cy[COORD_W], cy};

	// half-open bounds on both axes
	assign stat.hit = (px >= entry.x) && ($signed({px[COORD_W-1], px}) < x_end) &&
	                  (py >= entry.y) && ($signed({py[COORD_W-1], py}) < y_end);

	// shared squarer
	assign mult_a = ctrl.sqy ? dy_q : dx_q;
	assign prod   = mult_a * mult_a;

	assign dist_sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign stat.closer = dist_sum < {{(SQ_W + 1 - 32){1'b0}}, best_q};

	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			dx_q <= dx;
			dy_q <= dy;
		end
		if (ctrl.sqx) begin
			sqx_q <= $unsigned(prod);
		end
		if (ctrl.sqy) begin
			sqy_q <= $unsigned(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= BEST_INIT;
		end else if (ctrl.clear) begin
			best_q <= BEST_INIT;
		end else if (ctrl.acc && stat.closer) begin
			best_q <= dist_sum[31:0];
		end
	end

endmodule
`default_nettype wire

@@ hdl/nearest_region_lookup_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_region_lookup_top: containing or nearest rectangle search
// Holds a table of rectangles loaded by beats on the request channel and
// answers point queries with the first containing entry, else the entry with
// the nearest centre, with a one-point result cache.
//
// channel    handshake            beat contents
// apb        psel/penable/pready  region_count at address 0
// request    req_valid/req_stall  cmd, entry_index, point, rectangle
// response   rsp_valid/rsp_stall  region_index, one per query
//
// a query that hits the cache goes straight from IDLE to OUT; a scanned
// query passes each entry through FETCH, EVAL, SQX and SQY to ACC, set by the
// shared squarer and the registered table read of one entry per pass
// request stalls for the whole scan and while a result waits to enter the
// output register; reset leaves the cache empty and region_count at 1
// ----------------------------------------------------------------------------
module nearest_region_lookup_top
	import nrl_pkg::*;
#(
	parameter int MAX_REGIONS = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [PADDR_W-1:0]         paddr,
	input  wire [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  wire                       req_valid,
	output logic                      req_stall,
	input  wire                       cmd,
	input  wire [2:0]                 entry_index,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic signed [COORD_W-1:0] rect_x,
	input  wire logic signed [COORD_W-1:0] rect_y,
	input  wire [DIM_W-1:0]           rect_width,
	input  wire [DIM_W-1:0]           rect_height,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output logic [OUT_W-1:0]          region_index
);

	localparam int          IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned MAXR  = MAX_REGIONS;

	state_t                     state_q;
	state_t                     state_d;
	dp_ctrl_t                   ctrl;
	dp_stat_t                   stat;

	logic [CNT_W-1:0]           region_count_q;
	logic                       cfg_wr;

	region_t                    mem [MAX_REGIONS];
	region_t                    rd_data_q;
	logic [IDX_W-1:0]           rd_addr;
	logic [IDX_W-1:0]           wr_addr;

	logic                       req_acc;
	logic                       is_load;
	logic                       is_query;
	logic                       load_ok;
	logic                       cache_hit;
	logic [31:0]                lim_full;

	logic                       cache_valid_q;
	logic signed [COORD_W-1:0]  cached_x_q;
	logic signed [COORD_W-1:0]  cached_y_q;
	logic [OUT_W-1:0]           cached_idx_q;
	logic signed [COORD_W-1:0]  px_q;
	logic signed [COORD_W-1:0]  py_q;
	logic [IDX_W:0]             scan_idx_q;
	logic [IDX_W:0]             lim_q;
	logic [IDX_W-1:0]           pick_q;
	logic                       out_load;
	logic                       rsp_valid_q;
	logic [OUT_W-1:0]           region_index_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_REGION_COUNT) begin
			prdata = {{(PDATA_W - CNT_W){1'b0}}, region_count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= CNT_W'(1);
		end else if (cfg_wr && (paddr[2] == REG_REGION_COUNT)) begin
			region_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// request decode
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign is_load   = req_acc && (cmd == CMD_LOAD);
	assign is_query  = req_acc && (cmd == CMD_QUERY);
	assign load_ok   = is_load && (32'(entry_index) < MAXR);
	assign cache_hit = cache_valid_q && (point_x == cached_x_q) && (point_y == cached_y_q);
	assign lim_full  = (32'(region_count_q) > MAXR) ? MAXR : 32'(region_count_q);

	// region table
	assign wr_addr = IDX_W'(entry_index);
	assign rd_addr = scan_idx_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[wr_addr] <= '{x: rect_x, y: rect_y, w: rect_width, h: rect_height};
		end
		rd_data_q <= mem[rd_addr];
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_query) begin
					state_d = cache_hit ? ST_OUT : ST_FETCH;
				end
			end
			ST_FETCH: state_d = (scan_idx_q == lim_q) ? ST_FIN : ST_EVAL;
			ST_EVAL:  state_d = stat.hit ? ST_FIN : ST_SQX;
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_FETCH;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl     = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  ctrl.clear = is_query && !cache_hit;
			ST_EVAL:  ctrl.eval  = 1'b1;
			ST_SQX:   ctrl.sqx   = 1'b1;
			ST_SQY:   ctrl.sqy   = 1'b1;
			ST_ACC:   ctrl.acc   = 1'b1;
			ST_OUT:   out_load   = !rsp_valid_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cache_valid_q <= 1'b0;
			cached_x_q    <= '0;
			cached_y_q    <= '0;
			cached_idx_q  <= '0;
			scan_idx_q    <= '0;
			lim_q         <= '0;
			pick_q        <= '0;
		end else begin
			state_q <= state_d;
			if (load_ok) begin
				cache_valid_q <= 1'b0;
			end
			if (is_query && !cache_hit) begin
				scan_idx_q <= '0;
				lim_q      <= lim_full[IDX_W:0];
				pick_q     <= '0;
			end
			if (state_q == ST_EVAL && stat.hit) begin
				pick_q <= rd_addr;
			end
			if (state_q == ST_ACC) begin
				if (stat.closer) begin
					pick_q <= rd_addr;
				end
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (state_q == ST_FIN) begin
				cache_valid_q <= 1'b1;
				cached_x_q    <= px_q;
				cached_y_q    <= py_q;
				cached_idx_q  <= OUT_W'(pick_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	nrl_dist_unit u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.entry  (rd_data_q),
		.px     (px_q),
		.py     (py_q),
		.stat   (stat)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			region_index_q <= cached_idx_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign region_index = region_index_q;

endmodule
`default_nettype wire
